FILE: rtl/nested_zone_tick_profiler_core_defines.svh
// Assertion macros shared by the profiler checker.
// Depends on nothing; the including file supplies i_clk and i_rst_n.
`ifndef NESTED_ZONE_TICK_PROFILER_CORE_DEFINES_SVH
`define NESTED_ZONE_TICK_PROFILER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define NZTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define NZTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nztp_pkg.sv
// Package for the zone tick profiler: sizes, op and status codes,
// the zone wrap table and the controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package nztp_pkg;

    localparam int ZONE_COUNT = 64;
    localparam int NEST_DEPTH = 16;

    localparam int OP_W     = 2;
    localparam int ZONE_W   = 6;
    localparam int TICK_W   = 64;
    localparam int HITS_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ZONE_NUM = 1 << ZONE_W;

    localparam int ZI_W  = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int LVL_W = $clog2(NEST_DEPTH + 1);
    localparam int PTR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
    localparam logic [OP_W-1:0] OP_EXIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [ZI_W-1:0] t_zone_lut [ZONE_NUM];

    // Zone field folded onto the counter array, worked out at elaboration
    function automatic t_zone_lut build_zone_lut();
        t_zone_lut lut;
        for (int i = 0; i < ZONE_NUM; i++) begin
            lut[i] = ZI_W'(i % ZONE_COUNT);
        end
        return lut;
    endfunction

    localparam t_zone_lut ZONE_LUT = build_zone_lut();

    typedef struct packed {
        logic accept;    // capture the input word, issue counter reads
        logic exit_mid;  // write parent self count, pop the stack
        logic exit_fin;  // write popped zone's counters, load result
        logic resp;      // push on a good enter, load result
    } t_cmd;

    typedef struct packed {
        logic exit_ok;   // offered word is an exit with a non-empty stack
        logic out_free;  // result register can take a new word
    } t_sts;

endpackage

FILE: rtl/nested_zone_tick_profiler_core.sv
// Zone tick profiler: an enter word names a zone and its start tick and pushes
// onto a nesting stack; an exit word pops the innermost zone, charges the elapsed
// ticks to that zone's self and total counts and takes them off its parent's self
// count; a read word (op 2 or 3) returns a zone's counters. Every word gives one
// result word. Enter and read do a counter read, then the result step; exit puts
// a parent self-count write between the two, since the parent's and the popped
// zone's self counts share in turn the one self-count write port. A stalled result
// holds the next back. Counters read as zero from reset without a clearing pass.
// Depends on nztp_pkg, nztp_ctrl and nztp_dp.
`timescale 1ns / 1ps

module nested_zone_tick_profiler_core
    import nztp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input word channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ZONE_W-1:0]   i_zone,
    input  logic [TICK_W-1:0]   i_tick,
    // result word channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [ZONE_W-1:0]   o_report_zone,
    output logic [TICK_W-1:0]   o_total_ticks,
    output logic [TICK_W-1:0]   o_self_ticks,
    output logic [HITS_W-1:0]   o_hits
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: take a word, then drive the read, update and result steps
    nztp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Counter arrays, nesting stack and the result register
    nztp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_zone        (i_zone),
        .i_tick        (i_tick),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_report_zone (o_report_zone),
        .o_total_ticks (o_total_ticks),
        .o_self_ticks  (o_self_ticks),
        .o_hits        (o_hits)
    );

endmodule

FILE: rtl/nztp_ctrl.sv
// Sequencing state machine of the zone tick profiler.
// Depends on nztp_pkg for the command and status structs.
`timescale 1ns / 1ps

module nztp_ctrl
    import nztp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RESP  = 4'b0010,
        S_EXPAR = 4'b0100,
        S_EXFIN = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = i_sts.exit_ok ? S_EXPAR : S_RESP;
                end
            end
            S_RESP: begin
                o_cmd.resp = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EXPAR: begin
                o_cmd.exit_mid = 1'b1;
                n_state        = S_EXFIN;
            end
            S_EXFIN: begin
                o_cmd.exit_fin = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/nztp_dp.sv
// Datapath of the zone tick profiler: counter arrays, nesting stack,
// elapsed arithmetic and result register. Depends on nztp_pkg.
`timescale 1ns / 1ps

module nztp_dp
    import nztp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ZONE_W-1:0]   i_zone,
    input  logic [TICK_W-1:0]   i_tick,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ZONE_W-1:0]   o_report_zone,
    output logic [TICK_W-1:0]   o_total_ticks,
    output logic [TICK_W-1:0]   o_self_ticks,
    output logic [HITS_W-1:0]   o_hits
);

    // Zone counter memories, no reset; valid bits stand in for the clear
    logic [TICK_W-1:0] m_total [ZONE_COUNT];
    logic [TICK_W-1:0] m_self  [ZONE_COUNT];
    logic [HITS_W-1:0] m_hits  [ZONE_COUNT];
    logic [ZONE_COUNT-1:0] r_v_th, r_v_self;

    // Nesting stack
    logic [ZI_W-1:0]   stk_zone  [NEST_DEPTH];
    logic [ZI_W-1:0]   stk_par   [NEST_DEPTH];
    logic [TICK_W-1:0] stk_start [NEST_DEPTH];
    logic [TICK_W-1:0] stk_old   [NEST_DEPTH];

    logic [LVL_W-1:0] r_level;
    logic [ZI_W-1:0]  r_cur_parent;

    // Captured item
    logic [OP_W-1:0]   r_op;
    logic [ZI_W-1:0]   r_zone, r_pz, r_par;
    logic [TICK_W-1:0] r_tick, r_elapsed, r_old_total;

    // Registered read data
    logic [TICK_W-1:0] r_rd_total, r_rd_self_a, r_rd_self_b;
    logic [HITS_W-1:0] r_rd_hits;
    logic              r_rd_th_v, r_rd_self_a_v, r_rd_self_b_v;

    // Exit results held for the final write
    logic [TICK_W-1:0] r_new_total, r_new_self;
    logic [HITS_W-1:0] r_new_hits;

    logic              r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [ZONE_W-1:0] r_o_zone;
    logic [TICK_W-1:0] r_o_total, r_o_self;
    logic [HITS_W-1:0] r_o_hits;

    logic [LVL_W-1:0]  top_lvl;
    logic [PTR_W-1:0]  top_ptr, push_ptr;
    logic [ZI_W-1:0]   in_zone, top_zone, top_par, rd_addr_a;
    logic              stk_empty, stk_full, is_exit, is_enter;
    logic [TICK_W-1:0] eff_total, eff_self_a, eff_self_b;
    logic [HITS_W-1:0] eff_hits;
    logic              self_we;
    logic [ZI_W-1:0]   self_waddr;
    logic [TICK_W-1:0] self_wdata;

    assign top_lvl   = r_level - LVL_W'(1);
    assign top_ptr   = top_lvl[PTR_W-1:0];
    assign push_ptr  = r_level[PTR_W-1:0];
    assign stk_empty = (r_level == '0);
    assign stk_full  = (r_level == LVL_W'(NEST_DEPTH));
    assign in_zone   = ZONE_LUT[i_zone];
    assign top_zone  = stk_zone[top_ptr];
    assign top_par   = stk_par[top_ptr];
    assign is_exit   = (i_op == OP_EXIT);
    assign rd_addr_a = is_exit ? top_zone : in_zone;
    assign is_enter  = (r_op == OP_ENTER);

    assign o_sts.exit_ok  = is_exit && !stk_empty;
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign eff_total  = r_rd_th_v     ? r_rd_total  : '0;
    assign eff_hits   = r_rd_th_v     ? r_rd_hits   : '0;
    assign eff_self_a = r_rd_self_a_v ? r_rd_self_a : '0;
    assign eff_self_b = r_rd_self_b_v ? r_rd_self_b : '0;

    // Single write port on the self array: parent first, then popped zone
    assign self_we    = i_cmd.exit_mid || i_cmd.exit_fin;
    assign self_waddr = i_cmd.exit_mid ? r_par : r_pz;
    assign self_wdata = i_cmd.exit_mid ? (eff_self_b - r_elapsed) : r_new_self;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_total    <= m_total[rd_addr_a];
            r_rd_hits     <= m_hits[rd_addr_a];
            r_rd_self_a   <= m_self[rd_addr_a];
            r_rd_self_b   <= m_self[top_par];
            r_rd_th_v     <= r_v_th[rd_addr_a];
            r_rd_self_a_v <= r_v_self[rd_addr_a];
            r_rd_self_b_v <= r_v_self[top_par];
        end
        if (self_we) begin
            m_self[self_waddr] <= self_wdata;
        end
        if (i_cmd.exit_fin) begin
            m_total[r_pz] <= r_new_total;
            m_hits[r_pz]  <= r_new_hits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op        <= i_op;
            r_zone      <= in_zone;
            r_tick      <= i_tick;
            r_pz        <= top_zone;
            r_par       <= top_par;
            r_elapsed   <= i_tick - stk_start[top_ptr];
            r_old_total <= stk_old[top_ptr];
        end
        if (i_cmd.exit_mid) begin
            // parent and zone equal: subtract and add cancel
            r_new_self  <= (r_par == r_pz) ? eff_self_a : eff_self_a + r_elapsed;
            r_new_total <= r_old_total + r_elapsed;
            r_new_hits  <= eff_hits + HITS_W'(1);
        end
        if (i_cmd.resp && is_enter && !stk_full) begin
            stk_zone[push_ptr]  <= r_zone;
            stk_par[push_ptr]   <= r_cur_parent;
            stk_start[push_ptr] <= r_tick;
            stk_old[push_ptr]   <= eff_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= '0;
            r_cur_parent <= '0;
            r_v_th       <= '0;
            r_v_self     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (self_we) begin
                r_v_self[self_waddr] <= 1'b1;
            end
            if (i_cmd.exit_fin) begin
                r_v_th[r_pz] <= 1'b1;
            end
            if (i_cmd.exit_mid) begin
                r_level      <= top_lvl;
                r_cur_parent <= r_par;
            end else if (i_cmd.resp && is_enter && !stk_full) begin
                r_level      <= r_level + LVL_W'(1);
                r_cur_parent <= r_zone;
            end
            if (i_cmd.resp || i_cmd.exit_fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exit_fin) begin
            r_o_status <= ST_OK;
            r_o_zone   <= ZONE_W'(r_pz);
            r_o_total  <= r_new_total;
            r_o_self   <= r_new_self;
            r_o_hits   <= r_new_hits;
        end else if (i_cmd.resp) begin
            priority if (r_op == OP_EXIT) begin
                r_o_status <= ST_EMPTY;
                r_o_zone   <= '0;
                r_o_total  <= '0;
                r_o_self   <= '0;
                r_o_hits   <= '0;
            end else begin
                r_o_status <= (is_enter && stk_full) ? ST_FULL : ST_OK;
                r_o_zone   <= ZONE_W'(r_zone);
                r_o_total  <= eff_total;
                r_o_self   <= eff_self_a;
                r_o_hits   <= eff_hits;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_report_zone = r_o_zone;
    assign o_total_ticks = r_o_total;
    assign o_self_ticks  = r_o_self;
    assign o_hits        = r_o_hits;

endmodule

FILE: rtl/nztp_checker.sv
// Port-level checks for the zone tick profiler, bound to the top level.
// Depends on nztp_pkg and nested_zone_tick_profiler_core_defines.svh.
`timescale 1ns / 1ps
`include "nested_zone_tick_profiler_core_defines.svh"

module nztp_checker
    import nztp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [ZONE_W-1:0]   o_report_zone,
    input logic [TICK_W-1:0]   o_total_ticks,
    input logic [TICK_W-1:0]   o_self_ticks,
    input logic [HITS_W-1:0]   o_hits
);

    // Hold a stalled result word
    `NZTP_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_status) && $stable(o_report_zone)
            && $stable(o_total_ticks) && $stable(o_self_ticks) && $stable(o_hits),
        "stalled result changed")

    // An empty-stack exit reports nothing but its status
    `NZTP_ASSERT_NOW(a_empty_zero, o_valid && (o_status == ST_EMPTY),
        (o_report_zone == '0) && (o_total_ticks == '0) && (o_self_ticks == '0)
            && (o_hits == '0),
        "empty status with payload")

    // One word at a time: the input side stalls right after an accept
    `NZTP_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall,
        "second word taken while busy")

endmodule

bind nested_zone_tick_profiler_core nztp_checker u_nztp_checker (.*);

FILE: dv/nested_zone_tick_profiler_core_tb.sv
// Self-checking bench for nested_zone_tick_profiler_core: directed and random
// enter/exit/read words against a predictor of the zone counters and nesting stack.
// Depends on nztp_pkg and the profiler RTL only.
`timescale 1ns / 1ps

module nested_zone_tick_profiler_core_tb;
    import nztp_pkg::*;

    // op 3 has no name in the package; the block treats it as a read
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_WORDS   = 900;
    localparam int QUIET_WORDS    = 120;   // tail of the run with no idling
    localparam int DRAIN_CYCLES   = 20;    // settle time after the last report
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
    localparam int REPORT_LIMIT   = 10;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ZONE_W-1:0]   zone;
        logic [TICK_W-1:0]   incl;
        logic [TICK_W-1:0]   excl;
        logic [HITS_W-1:0]   hits;
    } t_zone_report;

    // Predicts the report word for each accepted word and keeps the
    // reports still owed by the block, oldest first.
    class t_zone_counter_predictor;
        logic [TICK_W-1:0] incl_ticks  [ZONE_COUNT];
        logic [TICK_W-1:0] excl_ticks  [ZONE_COUNT];
        logic [HITS_W-1:0] visit_count [ZONE_COUNT];
        int                parent_zone;
        int                nest_zone   [NEST_DEPTH];
        int                nest_parent [NEST_DEPTH];
        logic [TICK_W-1:0] nest_start  [NEST_DEPTH];
        logic [TICK_W-1:0] nest_old    [NEST_DEPTH];
        int                nest_level;
        t_zone_report      pending_reports[$];
        int                mismatches;

        function new();
            foreach (incl_ticks[i]) begin
                incl_ticks[i]  = '0;
                excl_ticks[i]  = '0;
                visit_count[i] = '0;
            end
            parent_zone = 0;
            nest_level  = 0;
            mismatches  = 0;
        endfunction

        function t_zone_report counters_of(logic [STATUS_W-1:0] status, int zi);
            t_zone_report rep;
            rep.status = status;
            rep.zone   = ZONE_W'(zi);
            rep.incl   = incl_ticks[zi];
            rep.excl   = excl_ticks[zi];
            rep.hits   = visit_count[zi];
            return rep;
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [ZONE_W-1:0] zone,
                                logic [TICK_W-1:0] tick);
            int                zi;
            int                top;
            int                pz;
            int                par;
            logic [TICK_W-1:0] elapsed;
            t_zone_report      rep;
            zi = int'(zone) % ZONE_COUNT;
            if (op == OP_ENTER) begin
                if (nest_level >= NEST_DEPTH) begin
                    rep = counters_of(ST_FULL, zi);
                end else begin
                    nest_zone[nest_level]   = zi;
                    nest_parent[nest_level] = parent_zone;
                    nest_start[nest_level]  = tick;
                    nest_old[nest_level]    = incl_ticks[zi];
                    nest_level++;
                    parent_zone = zi;
                    rep = counters_of(ST_OK, zi);
                end
            end else if (op == OP_EXIT) begin
                if (nest_level == 0) begin
                    rep = '{ST_EMPTY, '0, '0, '0, '0};
                end else begin
                    top     = nest_level - 1;
                    pz      = nest_zone[top];
                    par     = nest_parent[top];
                    elapsed = tick - nest_start[top];
                    nest_level  = top;
                    parent_zone = par;
                    // parent first, so a zone that is its own parent nets to zero
                    excl_ticks[par] = excl_ticks[par] - elapsed;
                    excl_ticks[pz]  = excl_ticks[pz] + elapsed;
                    incl_ticks[pz]  = nest_old[top] + elapsed;
                    visit_count[pz] = visit_count[pz] + 1'b1;
                    rep = counters_of(ST_OK, pz);
                end
            end else begin
                rep = counters_of(ST_OK, zi);
            end
            pending_reports.push_back(rep);
        endfunction

        function void check_report(t_zone_report got);
            t_zone_report want;
            bit           bad;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected report: status %0d zone %0d", $realtime,
                             got.status, got.zone);
                return;
            end
            want = pending_reports.pop_front();
            bad  = 1'b0;
            if (got.status !== want.status) bad = 1'b1;
            if (got.zone   !== want.zone)   bad = 1'b1;
            if (got.incl   !== want.incl)   bad = 1'b1;
            if (got.excl   !== want.excl)   bad = 1'b1;
            if (got.hits   !== want.hits)   bad = 1'b1;
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: report mismatch", $realtime);
                    $display("  expected status %0d zone %0d total %h self %h hits %0d",
                             want.status, want.zone, want.incl, want.excl, want.hits);
                    $display("  actual   status %0d zone %0d total %h self %h hits %0d",
                             got.status, got.zone, got.incl, got.excl, got.hits);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [OP_W-1:0]     i_op;
    logic [ZONE_W-1:0]   i_zone;
    logic [TICK_W-1:0]   i_tick;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [ZONE_W-1:0]   o_report_zone;
    logic [TICK_W-1:0]   o_total_ticks;
    logic [TICK_W-1:0]   o_self_ticks;
    logic [HITS_W-1:0]   o_hits;

    t_zone_counter_predictor profile;
    bit                      quiet;       // no idling on either side once set
    int                      idle_cycles;
    int                      stall_left;
    bit                      stall_on;

    nested_zone_tick_profiler_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_zone        (i_zone),
        .i_tick        (i_tick),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_report_zone (o_report_zone),
        .o_total_ticks (o_total_ticks),
        .o_self_ticks  (o_self_ticks),
        .o_hits        (o_hits)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Sample both channels at the rising edge. Check the outgoing report before
    // noting the incoming word; the block cannot answer a word in its own cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                profile.check_report('{o_status, o_report_zone, o_total_ticks,
                                       o_self_ticks, o_hits});
            if (i_valid && !o_stall)
                profile.note_word(i_op, i_zone, i_tick);
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
            $display("nested_zone_tick_profiler_core_tb: FAIL");
            $finish;
        end
    end

    // Result side back-pressure: draw random bursts, each one stalled with a chance
    // of one in three; hold the stall low once the quiet tail starts.
    initial begin
        i_stall    = 1'b0;
        stall_left = 0;
        stall_on   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                stall_on   = ($urandom_range(0, 2) == 0);
                stall_left = $urandom_range(1, 14);
            end
            stall_left--;
            i_stall = stall_on && !quiet && i_rst_n;
        end
    end

    // Offer one word at the falling edge and hold it until it is taken.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ZONE_W-1:0] zone,
                             input logic [TICK_W-1:0] tick);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_op    = op;
        i_zone  = zone;
        i_tick  = tick;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid for a random burst now and then, unless in the quiet tail.
    task automatic maybe_gap();
        int gap;
        if (quiet || $urandom_range(0, 3) != 0)
            return;
        gap = $urandom_range(1, 14);
        @(negedge i_clk);
        i_valid = 1'b0;
        repeat (gap - 1) @(negedge i_clk);
    endtask

    initial begin
        logic [TICK_W-1:0] now_tick;
        logic [OP_W-1:0]   op;
        logic [ZONE_W-1:0] zone;
        int                mode;
        int                mode_left;
        int                pick;
        int                enter_cut;
        int                exit_cut;

        profile     = new();
        quiet       = 1'b0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_op        = OP_READ;
        i_zone      = '0;
        i_tick      = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a read of cleared counters, exit on an empty stack,
        // recursion of one zone (parent equals zone), elapsed wrapping past
        // the top of the tick range, the spare op code, then fill the stack
        // and push once more to hit the full case.
        send_word(OP_READ,  6'd0,  '0);                 maybe_gap();
        send_word(OP_EXIT,  6'd63, TICK_MAX);           maybe_gap();
        send_word(OP_ENTER, 6'd63, TICK_MAX);           maybe_gap();
        send_word(OP_ENTER, 6'd63, 64'd5);              maybe_gap();
        send_word(OP_EXIT,  6'd0,  64'd40);             maybe_gap();
        send_word(OP_EXIT,  6'd21, 64'd9);              maybe_gap();
        send_word(OP_SPARE, 6'd63, {$urandom, $urandom}); maybe_gap();
        send_word(OP_READ,  6'd0,  TICK_MAX);           maybe_gap();
        now_tick = 64'd1000;
        for (int i = 0; i <= NEST_DEPTH; i++) begin
            send_word(OP_ENTER, ZONE_W'(i * 4 + 1), now_tick);
            maybe_gap();
            now_tick += TICK_W'($urandom_range(1, 500));
        end

        // Random: walk the stack depth through shallow, deep and draining
        // stretches so full and empty both recur. Ticks mostly advance by
        // small steps; now and then jump anywhere or sit just below the wrap.
        mode_left = 0;
        mode      = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS - QUIET_WORDS)
                quiet = 1'b1;
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(8, 30);
            end
            mode_left--;
            case (mode)
                0: begin enter_cut = 45; exit_cut = 88; end
                1: begin enter_cut = 72; exit_cut = 90; end
                default: begin enter_cut = 15; exit_cut = 90; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < enter_cut)
                op = OP_ENTER;
            else if (pick < exit_cut)
                op = OP_EXIT;
            else
                op = ($urandom_range(0, 4) == 0) ? OP_SPARE : OP_READ;

            // A small working set gives recursion and self-parenting often
            if ($urandom_range(0, 3) == 0)
                zone = ZONE_W'($urandom_range(0, 63));
            else
                zone = ZONE_W'($urandom_range(0, 7));

            pick = $urandom_range(0, 19);
            if (pick == 0)
                now_tick = {$urandom, $urandom};
            else if (pick == 1)
                now_tick = TICK_MAX - TICK_W'($urandom_range(0, 3000));
            else
                now_tick += TICK_W'($urandom_range(1, 2000));

            send_word(op, zone, now_tick);
            maybe_gap();
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        // Wait for every owed report, then let the block settle.
        while (profile.pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (profile.pending_reports.size() != 0)
            $display("%0d expected reports never arrived", profile.pending_reports.size());
        if (profile.mismatches == 0 && profile.pending_reports.size() == 0)
            $display("nested_zone_tick_profiler_core_tb: PASS");
        else
            $display("nested_zone_tick_profiler_core_tb: FAIL");
        $finish;
    end

endmodule
